// ===== design/pba_pkg.sv =====
`default_nettype none
package pba_pkg;

  // width of page numbers, page counts and search positions
  localparam int PIDX_W = 26;

  typedef enum logic [1:0] {
    OP_RESERVE = 2'd0,
    OP_FREE    = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_ZERO     = 3'd1,
    STS_BEYOND   = 3'd2,
    STS_CONFLICT = 3'd3,
    STS_NOSPACE  = 3'd4
  } status_e;

  // per-request plan worked out from the captured request
  typedef struct packed {
    status_e           status;
    logic [PIDX_W-1:0] s;
    logic [PIDX_W-1:0] e;
    logic [PIDX_W-1:0] pref;
    logic [PIDX_W-1:0] need;
    logic [PIDX_W-1:0] lim;
    logic [4:0]        slog;
    logic              sub_page;
  } plan_t;

endpackage
`default_nettype wire

// ===== design/pba_decode.sv =====
`default_nettype none
module pba_decode import pba_pkg::*; #(
  parameter int PAGES     = 4096,
  parameter int PAGE_BITS = 12
) (
  input  op_e         operation_i,
  input  logic [31:0] byte_address_i,
  input  logic [31:0] byte_count_i,
  input  logic [4:0]  align_log2_i,
  input  logic [31:0] goal_address_i,
  input  logic [19:0] base_page_i,
  input  logic [19:0] end_page_i,
  output plan_t       plan_o
);

  localparam int XW = (PAGE_BITS + 21 > 34) ? PAGE_BITS + 21 : 34;

  logic [XW-1:0] addr_x, size_x, base_x, basep_x, goal_x, end_x, pmask, align_x;
  logic [XW-1:0] rsv_endp, rsv_s, rsv_e, fre_endp, fre_s, fre_e, e_raw;
  logic [XW-1:0] pref_b, pref_r, need_x, lim_x;
  logic [20:0]   span;
  logic          below, goal_ok;

  always_comb begin
    addr_x  = XW'(byte_address_i);
    size_x  = XW'(byte_count_i);
    goal_x  = XW'(goal_address_i);
    base_x  = XW'({base_page_i, {PAGE_BITS{1'b0}}});
    basep_x = XW'(base_page_i);
    end_x   = XW'(end_page_i);
    pmask   = XW'({PAGE_BITS{1'b1}});
    align_x = XW'(1) << align_log2_i;

    span  = {1'b0, end_page_i} - {1'b0, base_page_i};
    if (end_page_i <= base_page_i) begin
      lim_x = '0;
    end else if (XW'(span) > XW'(PAGES)) begin
      lim_x = XW'(PAGES);
    end else begin
      lim_x = XW'(span);
    end

    below    = addr_x < base_x;
    rsv_endp = (addr_x + size_x + pmask) >> PAGE_BITS;
    rsv_s    = (addr_x - base_x) >> PAGE_BITS;
    rsv_e    = (addr_x + size_x - base_x + pmask) >> PAGE_BITS;
    fre_endp = (addr_x + size_x) >> PAGE_BITS;
    fre_s    = ((addr_x + pmask) >> PAGE_BITS) - basep_x;
    fre_e    = (addr_x + size_x - base_x) >> PAGE_BITS;

    goal_ok = (goal_address_i != '0) && (goal_x >= base_x) &&
              ((goal_x >> PAGE_BITS) < end_x);
    pref_b  = goal_ok ? goal_x - base_x : '0;
    pref_r  = (pref_b + align_x - XW'(1)) & ~(align_x - XW'(1));
    need_x  = (size_x + pmask) >> PAGE_BITS;

    plan_o          = '0;
    plan_o.status   = STS_OK;
    plan_o.lim      = PIDX_W'(lim_x);
    plan_o.pref     = PIDX_W'(pref_r >> PAGE_BITS);
    plan_o.need     = PIDX_W'(need_x);
    plan_o.sub_page = align_log2_i <= 5'(PAGE_BITS);
    plan_o.slog     = (align_log2_i > 5'(PAGE_BITS)) ? align_log2_i - 5'(PAGE_BITS) : 5'd0;

    if (operation_i == OP_FREE) begin
      plan_o.s = PIDX_W'(fre_s);
      e_raw    = fre_e;
    end else begin
      plan_o.s = PIDX_W'(rsv_s);
      e_raw    = rsv_e;
    end
    plan_o.e = (e_raw > lim_x) ? PIDX_W'(lim_x) : PIDX_W'(e_raw);

    case (operation_i)
      OP_NONE: plan_o.status = STS_OK;
      OP_RESERVE: begin
        if (byte_count_i == '0) plan_o.status = STS_ZERO;
        else if (rsv_endp > end_x || below) plan_o.status = STS_BEYOND;
      end
      OP_FREE: begin
        if (byte_count_i == '0) plan_o.status = STS_ZERO;
        else if (fre_endp > end_x || below) plan_o.status = STS_BEYOND;
      end
      default: begin
        if (byte_count_i == '0) plan_o.status = STS_ZERO;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== design/page_bitmap_boot_allocator.sv =====
// Boot-time page allocator over a one-bit-per-page map held in a word memory
// with one read and one write port (32 pages per word). After reset a clearing
// pass marks every page reserved, one map word at a time; no request is taken
// during it. Each request is then captured, planned and handed out through
// the result register. A reserve, free or allocation marks each of its pages
// with a read-modify-write of one map word, and an allocation first runs a
// first-fit search that examines one page at a time, once from the goal and
// once more from page zero on a miss, ends each pass and then places the block.
// The input stays not ready until the result has moved into the output
// register. The map memory ports move one word per cycle and pace every step.
`default_nettype none
module page_bitmap_boot_allocator import pba_pkg::*; #(
  parameter int PAGES     = 4096,
  parameter int PAGE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [19:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [31:0] byte_address_i,
  input  logic [31:0] byte_count_i,
  input  logic [4:0]  align_log2_i,
  input  logic [31:0] goal_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_address_o,
  output logic [2:0]  status_o,
  output logic        reserved_twice_o
);

  localparam int MAP_WORDS = (PAGES + 31) / 32;
  localparam int WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int LW        = $clog2(PAGES);

  typedef enum logic [8:0] {
    S_INIT     = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_PLAN     = 9'b000000100,
    S_SCAN_RD  = 9'b000001000,
    S_SCAN_TST = 9'b000010000,
    S_PACK     = 9'b000100000,
    S_RD       = 9'b001000000,
    S_WR       = 9'b010000000,
    S_DONE     = 9'b100000000
  } state_e;

  state_e            state_q, state_d;
  logic [WW-1:0]     init_q, init_d;
  logic [19:0]       base_q, end_q;
  op_e               op_q, op_d;
  logic [31:0]       addr_in_q, addr_in_d, size_q, size_d, goal_q, goal_d;
  logic [4:0]        alog_q, alog_d;
  plan_t             plan, plan_q, plan_d;
  logic [PIDX_W-1:0] i_q, i_d, e_q, e_d, cand_q, cand_d, p_q, p_d;
  logic              retry_q, retry_d, twice_q, twice_d;
  status_e           sts_q, sts_d;
  logic [31:0]       addr_q, addr_d;
  logic [LW-1:0]     last_q, last_d;
  logic [PAGE_BITS-1:0] tail_q, tail_d;

  logic              out_valid_q;
  logic [31:0]       res_addr_q;
  status_e           res_sts_q;
  logic              res_twice_q;

  logic [31:0]       map_mem [MAP_WORDS];
  logic [31:0]       rdata_q, mem_wdata, mask;
  logic [WW-1:0]     mem_waddr, mem_raddr;
  logic              mem_we, load_out;

  // scan and pack helpers
  logic [PIDX_W:0]    end_cand;
  logic [PIDX_W-1:0]  next_cand, need_eff;
  logic [PAGE_BITS:0] align_p, off, room;
  logic [31:0]        rest, new_tail;
  logic [32:0]        rest_up;
  logic [47:0]        pack_addr, plain_addr, base_bytes;
  logic               pack_ok;

  pba_decode #(.PAGES(PAGES), .PAGE_BITS(PAGE_BITS)) u_decode (
    .operation_i    (op_q),
    .byte_address_i (addr_in_q),
    .byte_count_i   (size_q),
    .align_log2_i   (alog_q),
    .goal_address_i (goal_q),
    .base_page_i    (base_q),
    .end_page_i     (end_q),
    .plan_o         (plan)
  );

  assign in_ready_o       = state_q == S_IDLE;
  assign out_valid_o      = out_valid_q;
  assign result_address_o = res_addr_q;
  assign status_o         = res_sts_q;
  assign reserved_twice_o = res_twice_q;
  assign load_out         = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    end_cand   = {1'b0, cand_q} + {1'b0, plan_q.need};
    next_cand  = PIDX_W'(((p_q >> plan_q.slog) + PIDX_W'(1)) << plan_q.slog);
    base_bytes = 48'({base_q, {PAGE_BITS{1'b0}}});
    align_p    = (PAGE_BITS+1)'(1) << alog_q;
    off        = ((PAGE_BITS+1)'(tail_q) + align_p - (PAGE_BITS+1)'(1)) &
                 ~(align_p - (PAGE_BITS+1)'(1));
    room       = (PAGE_BITS+1)'(1) << PAGE_BITS;
    room       = room - off;
    rest       = size_q - 32'(room);
    rest_up    = 33'(rest) + 33'({PAGE_BITS{1'b1}});
    new_tail   = size_q + 32'(off);
    pack_ok    = plan_q.sub_page && (tail_q != '0) &&
                 (PIDX_W'(last_q) + PIDX_W'(1) == cand_q);
    pack_addr  = 48'({last_q, {PAGE_BITS{1'b0}}}) + 48'(off) + base_bytes;
    plain_addr = 48'({cand_q, {PAGE_BITS{1'b0}}}) + base_bytes;
    mask       = 32'(1) << i_q[4:0];
  end

  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    op_d      = op_q;
    addr_in_d = addr_in_q;
    size_d    = size_q;
    goal_d    = goal_q;
    alog_d    = alog_q;
    plan_d    = plan_q;
    i_d       = i_q;
    e_d       = e_q;
    cand_d    = cand_q;
    p_d       = p_q;
    retry_d   = retry_q;
    twice_d   = twice_q;
    sts_d     = sts_q;
    addr_d    = addr_q;
    last_d    = last_q;
    tail_d    = tail_q;
    need_eff  = plan_q.need;
    mem_we    = 1'b0;
    mem_waddr = i_q[WW+4:5];
    mem_wdata = rdata_q;
    mem_raddr = i_q[WW+4:5];

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_q;
        mem_wdata = '1;
        init_d    = init_q + WW'(1);
        if (init_q == WW'(MAP_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          op_d      = op_e'(operation_i);
          addr_in_d = byte_address_i;
          size_d    = byte_count_i;
          goal_d    = goal_address_i;
          alog_d    = align_log2_i;
          state_d   = S_PLAN;
        end
      end
      S_PLAN: begin
        plan_d  = plan;
        twice_d = 1'b0;
        addr_d  = '0;
        sts_d   = plan.status;
        if (op_q == OP_NONE || plan.status != STS_OK) begin
          state_d = S_DONE;
        end else if (op_q == OP_ALLOC) begin
          cand_d  = plan.pref;
          p_d     = plan.pref;
          retry_d = plan.pref != '0;
          state_d = S_SCAN_RD;
        end else begin
          i_d     = plan.s;
          e_d     = plan.e;
          state_d = S_RD;
        end
      end
      S_SCAN_RD: begin
        mem_raddr = p_q[WW+4:5];
        if (end_cand > {1'b0, plan_q.lim}) begin
          // miss: one more pass from page zero if the search began at a nonzero goal, else no space
          if (retry_q) begin
            cand_d  = '0;
            p_d     = '0;
            retry_d = 1'b0;
          end else begin
            sts_d   = STS_NOSPACE;
            state_d = S_DONE;
          end
        end else if ({1'b0, p_q} == end_cand) begin
          state_d = S_PACK;
        end else begin
          state_d = S_SCAN_TST;
        end
      end
      S_SCAN_TST: begin
        if (rdata_q[p_q[4:0]]) begin
          cand_d = next_cand;
          p_d    = next_cand;
        end else begin
          p_d = p_q + PIDX_W'(1);
        end
        state_d = S_SCAN_RD;
      end
      S_PACK: begin
        // requests aligned to at most a page continue in the unused tail of the last page
        if (pack_ok) begin
          addr_d = pack_addr[31:0];
          if (32'(room) > size_q) begin
            need_eff = '0;
            tail_d   = new_tail[PAGE_BITS-1:0];
          end else begin
            need_eff = PIDX_W'(rest_up >> PAGE_BITS);
            last_d   = LW'(cand_q + need_eff - PIDX_W'(1));
            tail_d   = rest[PAGE_BITS-1:0];
          end
        end else begin
          addr_d = plain_addr[31:0];
          last_d = LW'(cand_q + plan_q.need - PIDX_W'(1));
          tail_d = size_q[PAGE_BITS-1:0];
        end
        i_d     = cand_q;
        e_d     = cand_q + need_eff;
        state_d = S_RD;
      end
      S_RD: begin
        if (i_q >= e_q) state_d = S_DONE;
        else state_d = S_WR;
      end
      S_WR: begin
        i_d     = i_q + PIDX_W'(1);
        state_d = S_RD;
        case (op_q)
          OP_FREE: begin
            if (!rdata_q[i_q[4:0]]) begin
              sts_d   = STS_CONFLICT;
              state_d = S_DONE;
            end else begin
              mem_we    = 1'b1;
              mem_wdata = rdata_q & ~mask;
            end
          end
          OP_RESERVE: begin
            twice_d   = twice_q | rdata_q[i_q[4:0]];
            mem_we    = 1'b1;
            mem_wdata = rdata_q | mask;
          end
          default: begin
            mem_we    = 1'b1;
            mem_wdata = rdata_q | mask;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    rdata_q <= map_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_q      <= '0;
      base_q      <= '0;
      end_q       <= 20'd4096;
      last_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      last_q  <= last_d;
      tail_q  <= tail_d;
      if (cfg_we_i) begin
        if (cfg_index_i) end_q <= cfg_data_i;
        else base_q <= cfg_data_i;
      end
      if (load_out) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    addr_in_q <= addr_in_d;
    size_q    <= size_d;
    goal_q    <= goal_d;
    alog_q    <= alog_d;
    plan_q    <= plan_d;
    i_q       <= i_d;
    e_q       <= e_d;
    cand_q    <= cand_d;
    p_q       <= p_d;
    retry_q   <= retry_d;
    twice_q   <= twice_d;
    sts_q     <= sts_d;
    addr_q    <= addr_d;
    if (load_out) begin
      res_addr_q  <= addr_q;
      res_sts_q   <= sts_q;
      res_twice_q <= twice_q;
    end
  end

endmodule
`default_nettype wire

// ===== design/pba_checker.sv =====
`default_nettype none
module pba_checker import pba_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] result_address_o,
  input wire logic [2:0]  status_o,
  input wire logic        reserved_twice_o
);

  // a waiting result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_address_o) &&
    $stable(status_o) && $stable(reserved_twice_o))
    else $error("result changed while stalled");

  a_sts_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= STS_NOSPACE)
    else $error("status out of range");

  a_fail_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != STS_OK |-> result_address_o == '0)
    else $error("address on failed request");

  a_twice_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reserved_twice_o |-> status_o == STS_OK)
    else $error("reserved twice flag with error status");

  // one request in flight: no new request on the edge after one is taken
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

endmodule

bind page_bitmap_boot_allocator pba_checker u_pba_checker (.*);
`default_nettype wire

// ===== tb/page_bitmap_boot_allocator_tb.sv =====
`default_nettype none
module page_bitmap_boot_allocator_tb;
  import pba_pkg::*;

  localparam int NPAGES = 4096;
  localparam int PBITS = 12;
  localparam longint unsigned PBYTES = 64'd1 << PBITS;
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_END = 1'b1;

  typedef struct {
    op_e         op;
    logic [31:0] addr;
    logic [31:0] count;
    logic [4:0]  alog;
    logic [31:0] goal;
  } page_req_t;

  typedef struct {
    logic [31:0] addr;
    status_e     status;
    logic        twice;
  } page_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [19:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  operation_i = '0;
  logic [31:0] byte_address_i = '0;
  logic [31:0] byte_count_i = '0;
  logic [4:0]  align_log2_i = '0;
  logic [31:0] goal_address_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] result_address_o;
  logic [2:0]  status_o;
  logic        reserved_twice_o;

  page_bitmap_boot_allocator dut (.*);

  // allocator state as the block should hold it
  bit             page_busy [NPAGES];
  int unsigned    free_run [NPAGES + 1];
  longint unsigned tail_page, tail_used, cur_base, cur_end;

  page_req_t req_q[$];
  page_res_t expected_q[$];
  int errors = 0;
  int n_sent = 0;
  int snd_idle = 16, rcv_idle = 55;
  bit taken = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit page_test(longint unsigned i);
    if (i >= NPAGES) return 1'b1;
    return page_busy[i];
  endfunction

  function automatic longint unsigned region_pages();
    longint unsigned n;
    if (cur_end <= cur_base) return 0;
    n = cur_end - cur_base;
    return (n > NPAGES) ? NPAGES : n;
  endfunction

  function automatic bit first_fit(longint unsigned from, longint unsigned need,
                                   longint unsigned incr, longint unsigned lim,
                                   output longint unsigned found);
    longint unsigned i;
    found = 0;
    for (i = from; i < lim; i += incr)
      if (free_run[i] >= need) begin
        found = i;
        return 1'b1;
      end
    return 1'b0;
  endfunction

  function automatic page_res_t allocator_result(page_req_t r);
    page_res_t res;
    longint unsigned addr, size, base_b, lim, i, s, e, endp;
    longint unsigned align, pref, need, incr, start, off, room, rest, a_out;
    bit ok;
    addr = r.addr;
    size = r.count;
    base_b = cur_base << PBITS;
    lim = region_pages();
    res.addr = '0;
    res.status = STS_OK;
    res.twice = 1'b0;
    if (r.op == OP_NONE) begin
    end else if (size == 0) begin
      res.status = STS_ZERO;
    end else if (r.op == OP_RESERVE) begin
      endp = (addr + size + PBYTES - 1) >> PBITS;
      if (endp > cur_end || addr < base_b) res.status = STS_BEYOND;
      else begin
        s = (addr - base_b) >> PBITS;
        e = (addr + size - base_b + PBYTES - 1) >> PBITS;
        if (e > lim) e = lim;
        for (i = s; i < e; i++) begin
          if (page_test(i)) res.twice = 1'b1;
          page_busy[i] = 1'b1;
        end
      end
    end else if (r.op == OP_FREE) begin
      endp = (addr + size) >> PBITS;
      if (endp > cur_end || addr < base_b) res.status = STS_BEYOND;
      else begin
        s = ((addr + PBYTES - 1) >> PBITS) - cur_base;
        e = (addr + size - base_b) >> PBITS;
        if (e > lim) e = lim;
        for (i = s; i < e; i++) begin
          if (!page_test(i)) begin
            res.status = STS_CONFLICT;
            break;
          end
          page_busy[i] = 1'b0;
        end
      end
    end else begin
      align = 64'd1 << r.alog;
      pref = 0;
      if (r.goal != 0 && r.goal >= base_b && (longint'(r.goal) >> PBITS) < cur_end)
        pref = r.goal - base_b;
      pref = ((pref + align - 1) & ~(align - 1)) >> PBITS;
      need = (size + PBYTES - 1) >> PBITS;
      incr = align >> PBITS;
      if (incr == 0) incr = 1;
      free_run[lim] = 0;
      for (i = lim; i > 0; i--)
        free_run[i-1] = page_test(i - 1) ? 0 : free_run[i] + 1;
      ok = first_fit(pref, need, incr, lim, start);
      if (!ok && pref != 0) ok = first_fit(0, need, incr, lim, start);
      if (!ok) res.status = STS_NOSPACE;
      else begin
        // requests aligned to at most a page share the tail of the last page handed out
        if (align <= PBYTES && tail_used != 0 && tail_page + 1 == start) begin
          off = (tail_used + align - 1) & ~(align - 1);
          room = PBYTES - off;
          a_out = (tail_page << PBITS) + off + base_b;
          if (size < room) begin
            need = 0;
            tail_used = (off + size) & (PBYTES - 1);
          end else begin
            rest = size - room;
            need = (rest + PBYTES - 1) >> PBITS;
            tail_page = start + need - 1;
            tail_used = rest & (PBYTES - 1);
          end
        end else begin
          tail_page = start + need - 1;
          tail_used = size & (PBYTES - 1);
          a_out = (start << PBITS) + base_b;
        end
        for (i = start; i < start + need; i++)
          if (i < NPAGES) page_busy[i] = 1'b1;
        res.addr = a_out[31:0];
      end
    end
    return res;
  endfunction

  // driver
  always @(negedge clk_i) begin
    page_req_t r;
    if (!in_valid_i || taken) begin
      if (req_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
        r = req_q.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= r.op;
        byte_address_i <= r.addr;
        byte_count_i <= r.count;
        align_log2_i <= r.alog;
        goal_address_i <= r.goal;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    taken = 0;
    out_ready_i <= ($urandom_range(99) >= rcv_idle);
  end

  // monitor
  always @(posedge clk_i) begin
    page_req_t r;
    page_res_t got, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r.op = op_e'(operation_i);
      r.addr = byte_address_i;
      r.count = byte_count_i;
      r.alog = align_log2_i;
      r.goal = goal_address_i;
      expected_q.push_back(allocator_result(r));
      taken = 1;
      n_sent++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.addr = result_address_o;
      got.status = status_e'(status_o);
      got.twice = reserved_twice_o;
      if (expected_q.size() == 0) begin
        $error("result with no request pending: addr %h status %0d", got.addr, got.status);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.addr !== want.addr) begin
          $error("result_address: expected %h actual %h", want.addr, got.addr);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          errors++;
        end
        if (got.twice !== want.twice) begin
          $error("reserved_twice: expected %0d actual %0d", want.twice, got.twice);
          errors++;
        end
      end
    end
  end

  task automatic cfg_write(logic idx, logic [19:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == CFG_BASE) cur_base = val;
    else cur_end = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (req_q.size() > 0 || in_valid_i || expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic void push(op_e op, longint unsigned addr, longint unsigned count,
                               int alog, longint unsigned goal);
    page_req_t r;
    r.op = op;
    r.addr = addr[31:0];
    r.count = count[31:0];
    r.alog = alog[4:0];
    r.goal = goal[31:0];
    req_q.push_back(r);
  endfunction

  // byte address inside the managed region, or anywhere when it is empty
  function automatic longint unsigned region_addr(longint unsigned span);
    if (span == 0) return $urandom;
    return ((cur_base + $urandom_range(span - 1)) << PBITS) + $urandom_range(PBYTES - 1);
  endfunction

  function automatic void random_request(longint unsigned span);
    int pick;
    longint unsigned cnt;
    pick = $urandom_range(99);
    if (pick < 8) begin
      // noise across the whole field ranges
      push(op_e'($urandom_range(3)), $urandom, $urandom, $urandom_range(31), $urandom);
      return;
    end
    case ($urandom_range(9))
      0: cnt = $urandom_range(PBYTES - 1) + 1;
      1: cnt = 0;
      default: cnt = $urandom_range(8 * PBYTES) + 1;
    endcase
    if (pick < 30)
      push(OP_RESERVE, region_addr(span), cnt, $urandom_range(31), $urandom);
    else if (pick < 60)
      push(OP_FREE, region_addr(span), cnt, $urandom_range(31), $urandom);
    else if (pick < 98)
      push(OP_ALLOC, $urandom, ($urandom_range(3) == 0) ? $urandom_range(PBYTES) + 1 : cnt,
           ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(14),
           ($urandom_range(2) == 0) ? 0 : region_addr(span));
    else
      push(OP_NONE, $urandom, $urandom, $urandom_range(31), $urandom);
  endfunction

  task automatic random_phase(logic [19:0] b, logic [19:0] e, int n);
    longint unsigned span;
    cfg_write(CFG_BASE, b);
    cfg_write(CFG_END, e);
    span = region_pages();
    // open the region so allocations have room to work
    if (span != 0) push(OP_FREE, cur_base << PBITS, span << PBITS, 0, 0);
    repeat (n) random_request(span);
    drain();
  endtask

  initial begin
    for (int i = 0; i < NPAGES; i++) page_busy[i] = 1'b1;
    tail_page = 0;
    tail_used = 0;
    cur_base = 0;
    cur_end = 4096;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed requests on the reset region
    push(OP_RESERVE, 0, 0, 0, 0);
    push(OP_FREE, 0, 0, 0, 0);
    push(OP_ALLOC, 0, 0, 0, 0);
    push(OP_ALLOC, 0, 1, 0, 0);
    push(OP_FREE, 0, 64 * PBYTES, 0, 0);
    push(OP_FREE, 100, 2 * PBYTES, 0, 0);
    push(OP_FREE, 0, PBYTES, 0, 0);
    push(OP_ALLOC, 0, 100, 3, 0);
    push(OP_ALLOC, 0, 200, 4, 0);
    push(OP_ALLOC, 0, PBYTES, 0, 0);
    push(OP_ALLOC, 0, 3 * PBYTES + 5, 12, 20 * PBYTES);
    push(OP_ALLOC, 0, 1, 31, 0);
    push(OP_ALLOC, 0, 32'hffff_ffff, 0, 0);
    push(OP_ALLOC, 0, 10, 0, 32'hffff_ffff);
    push(OP_RESERVE, 30 * PBYTES + 7, 5 * PBYTES, 0, 0);
    push(OP_RESERVE, 32'hffff_f000, 32'hffff_ffff, 0, 0);
    push(OP_FREE, 32'hffff_ffff, 1, 0, 0);
    push(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, 31, 32'hffff_ffff);
    push(OP_FREE, 0, NPAGES * PBYTES, 0, 0);
    push(OP_RESERVE, 0, NPAGES * PBYTES, 0, 0);
    push(OP_FREE, 4000 * PBYTES, 96 * PBYTES, 0, 0);
    drain();

    random_phase(20'd16, 20'd144, 300);
    // requests below the first managed byte
    push(OP_RESERVE, 0, PBYTES, 0, 0);
    push(OP_FREE, 15 * PBYTES, PBYTES, 0, 0);
    drain();
    random_phase(20'd1000, 20'd1100, 300);
    snd_idle = 55;
    rcv_idle = 16;
    random_phase(20'hFFF00, 20'hFFFFF, 300);
    random_phase(20'd0, 20'd0, 40);
    random_phase(20'd200, 20'd100, 40);
    random_phase(20'd5, 20'd5000, 30);
    snd_idle = 0;
    rcv_idle = 0;
    random_phase(20'd0, 20'hFFFFF, 30);
    random_phase(20'd300, 20'd364, 630);
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire
